[design/sbf_pkg.sv]
// Shared types and codes for the sprite blitter and its frame store.
`default_nettype none

package sbf_pkg;

    // Request modes
    localparam logic [1:0] MODE_DRAW  = 2'd0;
    localparam logic [1:0] MODE_ERASE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // One request word
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [7:0]         sprite_width;
        logic [7:0]         sprite_height;
        logic [7:0]         data_byte;
        logic               last_byte;
    } sbf_req_t;

    // One response word
    typedef struct packed {
        logic [7:0] read_data;
        logic       sprite_done;
    } sbf_rsp_t;

    // What a single frame store access does to its byte
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_SET  = 2'd1,
        OP_CLR  = 2'd2,
        OP_READ = 2'd3
    } sbf_op_kind_t;

    // Control for one read-modify-write pass
    typedef struct packed {
        sbf_op_kind_t kind;
        logic [7:0]   mask;
        logic         wr_en;
        logic         last_op;
        logic         done;
    } sbf_op_t;

endpackage

`default_nettype wire

[design/sbf_frame_mem.sv]
// Frame store memory: one write port, one registered read port, clearing sweep after reset.
`default_nettype none

module sbf_frame_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    output logic              busy
);

    logic [7:0]        mem [DEPTH];
    logic [7:0]        rd_data_reg;
    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // Clearing sweep control: one byte per cycle from address zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                clr_active_reg <= 1'b0;
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    // Storage array; the sweep owns the write port while it runs
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
            mem[clr_addr_reg] <= 8'h00;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_active_reg;

endmodule

`default_nettype wire

[design/sbf_issue.sv]
// Request register, sprite position counters and generation of frame store accesses.
`default_nettype none

module sbf_issue #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    localparam int PAGE_COUNT   = (SCREEN_HEIGHT + 7) / 8,
    localparam int STORE_DEPTH  = SCREEN_WIDTH * PAGE_COUNT,
    localparam int ADDR_W       = $clog2(STORE_DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  sbf_pkg::sbf_req_t req,
    input  logic              mem_busy,
    input  logic              final_room,
    output logic              op_valid,
    output sbf_pkg::sbf_op_t  op,
    output logic [ADDR_W-1:0] op_addr
);

    import sbf_pkg::*;

    localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int X_W    = $clog2(SCREEN_WIDTH);

    logic       item_valid_reg;
    logic       phase_reg;
    sbf_req_t   item_reg;
    logic [7:0] col_snap_reg;
    logic [4:0] band_snap_reg;
    logic [7:0] col_reg;
    logic [7:0] col_next;
    logic [4:0] band_reg;
    logic [4:0] band_next;

    logic              req_fire;
    logic              two_ops;
    logic              final_phase;
    logic [7:0]        pix_mask;
    logic [15:0]       shifted;
    logic [16:0]       x_sum;
    logic [16:0]       page_lo;
    logic [16:0]       page_hi;
    logic [ADDR_W-1:0] lo_idx;
    logic [ADDR_W-1:0] hi_idx;
    logic [ADDR_W-1:0] rd_idx;
    logic              rd_ok;

    function automatic logic [ADDR_W-1:0] AW_IDX(input logic [16:0] page,
                                                 input logic [16:0] col);
        logic [PAGE_W-1:0] pg;
        logic [X_W-1:0]    cx;
        pg = PAGE_W'(page);
        cx = X_W'(col);
        return ADDR_W'(ADDR_W'(pg) * ADDR_W'(SCREEN_WIDTH)) + ADDR_W'(cx);
    endfunction

    // Handshake and sequencing of the one or two accesses per word
    assign two_ops     = (item_reg.mode == MODE_DRAW) || (item_reg.mode == MODE_ERASE);
    assign final_phase = two_ops ? phase_reg : 1'b1;
    assign op_valid    = item_valid_reg && !mem_busy && (!final_phase || final_room);
    assign req_ready   = !mem_busy && (!item_valid_reg || (op_valid && final_phase));
    assign req_fire    = req_valid && req_ready;

    // Counter advance for draw and erase words
    always_comb
    begin
        logic [7:0] col_inc;
        col_inc   = col_reg + 8'd1;
        col_next  = col_reg;
        band_next = band_reg;
        if ((req.mode == MODE_DRAW) || (req.mode == MODE_ERASE))
        begin
            if (req.last_byte)
            begin
                col_next  = '0;
                band_next = '0;
            end
            else if ((col_inc >= req.sprite_width) || (col_inc == 8'd0))
            begin
                col_next  = '0;
                band_next = band_reg + 5'd1;
            end
            else
            begin
                col_next = col_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
            col_reg        <= '0;
            band_reg       <= '0;
        end
        else
        begin
            if (req_fire)
                item_valid_reg <= 1'b1;
            else if (op_valid && final_phase)
                item_valid_reg <= 1'b0;
            if (op_valid)
                phase_reg <= !final_phase;
            if (req_fire)
            begin
                col_reg  <= col_next;
                band_reg <= band_next;
            end
        end
    end

    // Word held with the counters it was placed at
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            item_reg      <= req;
            col_snap_reg  <= col_reg;
            band_snap_reg <= band_reg;
        end
    end

    // Per-pixel clipping: erase origin on screen, column, row against height, row on screen
    always_comb
    begin
        logic        active;
        logic        paint;
        logic [7:0]  row;
        logic [16:0] y_sum;
        x_sum = {item_reg.pos_x[15], item_reg.pos_x} + {9'b0, col_snap_reg};
        active = (item_reg.mode == MODE_DRAW)
              || (!item_reg.pos_x[15] && (item_reg.pos_x[14:0] < 15'(SCREEN_WIDTH))
                  && !item_reg.pos_y[15] && (item_reg.pos_y[14:0] < 15'(SCREEN_HEIGHT)));
        paint = two_ops && active && (col_snap_reg < item_reg.sprite_width)
             && !x_sum[16] && (x_sum[15:0] < 16'(SCREEN_WIDTH));
        for (int n = 0; n < 8; n++)
        begin
            row   = {band_snap_reg, 3'(n)};
            y_sum = {item_reg.pos_y[15], item_reg.pos_y} + {9'b0, row};
            pix_mask[n] = paint && item_reg.data_byte[n]
                       && (row < item_reg.sprite_height)
                       && !y_sum[16] && (y_sum[15:0] < 16'(SCREEN_HEIGHT));
        end
    end

    // Split the band across the two pages it straddles
    assign shifted = {8'b0, pix_mask} << item_reg.pos_y[2:0];
    assign page_lo = {{4{item_reg.pos_y[15]}}, item_reg.pos_y[15:3]} + {12'b0, band_snap_reg};
    assign page_hi = page_lo + 17'd1;
    assign lo_idx  = AW_IDX(page_lo, x_sum);
    assign hi_idx  = AW_IDX(page_hi, x_sum);

    // Read address check
    assign rd_ok  = !item_reg.pos_x[15] && (item_reg.pos_x[14:0] < 15'(SCREEN_WIDTH))
                 && !item_reg.pos_y[15] && (item_reg.pos_y[14:0] < 15'(PAGE_COUNT));
    assign rd_idx = AW_IDX({item_reg.pos_y[15], item_reg.pos_y},
                           {item_reg.pos_x[15], item_reg.pos_x});

    // Access for the current phase
    always_comb
    begin
        op.kind    = OP_NONE;
        op.mask    = '0;
        op.wr_en   = 1'b0;
        op.last_op = final_phase;
        op.done    = 1'b0;
        op_addr    = '0;
        case (item_reg.mode)
            MODE_DRAW, MODE_ERASE:
            begin
                op.kind = (item_reg.mode == MODE_DRAW) ? OP_SET : OP_CLR;
                if (!phase_reg)
                begin
                    op.mask  = shifted[7:0];
                    op.wr_en = (shifted[7:0] != 8'h00);
                    op_addr  = op.wr_en ? lo_idx : '0;
                end
                else
                begin
                    op.mask  = shifted[15:8];
                    op.wr_en = (shifted[15:8] != 8'h00);
                    op_addr  = op.wr_en ? hi_idx : '0;
                    op.done  = item_reg.last_byte;
                end
            end
            MODE_READ:
            begin
                op.kind = rd_ok ? OP_READ : OP_NONE;
                op_addr = rd_ok ? rd_idx : '0;
            end
            default:
            begin
                op.kind = OP_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/sbf_rmw.sv]
// Modify and write-back stage with forwarding, plus the two-word response queue.
`default_nettype none

module sbf_rmw #(
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    input  sbf_pkg::sbf_op_t  op,
    input  logic [ADDR_W-1:0] op_addr,
    input  logic [7:0]        rd_data,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [7:0]        wr_data,
    output logic              final_room,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output sbf_pkg::sbf_rsp_t rsp
);

    import sbf_pkg::*;

    logic              w_valid_reg;
    sbf_op_t           w_op_reg;
    logic [ADDR_W-1:0] w_addr_reg;
    logic              lw_valid_reg;
    logic [ADDR_W-1:0] lw_addr_reg;
    logic [7:0]        lw_data_reg;

    sbf_rsp_t   fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    logic       cur;
    logic [7:0] cur_byte;
    logic       push;
    logic       pop;
    logic [1:0] room_sum;
    sbf_rsp_t   rsp_word;

    // Stage registers: access now waiting for its read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg  <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            w_valid_reg  <= op_valid;
            lw_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        w_op_reg    <= op;
        w_addr_reg  <= op_addr;
        lw_addr_reg <= wr_addr;
        lw_data_reg <= wr_data;
    end

    // The write of the previous cycle is not yet in the read data
    assign cur      = lw_valid_reg && (lw_addr_reg == w_addr_reg);
    assign cur_byte = cur ? lw_data_reg : rd_data;

    always_comb
    begin
        case (w_op_reg.kind)
            OP_SET:  wr_data = cur_byte | w_op_reg.mask;
            OP_CLR:  wr_data = cur_byte & ~w_op_reg.mask;
            default: wr_data = cur_byte;
        endcase
    end

    assign wr_en   = w_valid_reg && w_op_reg.wr_en;
    assign wr_addr = w_addr_reg;

    // Response word for the final access of each request
    assign push                  = w_valid_reg && w_op_reg.last_op;
    assign rsp_word.read_data    = (w_op_reg.kind == OP_READ) ? cur_byte : 8'h00;
    assign rsp_word.sprite_done  = w_op_reg.done;

    // Response queue
    assign rsp_valid = (cnt_reg != 2'd0);
    assign rsp       = fifo_reg[rd_ptr_reg];
    assign pop       = rsp_valid && rsp_ready;
    assign cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};

    // A final access may start only if its word will find a free slot
    assign room_sum   = cnt_reg + {1'b0, push};
    assign final_room = (room_sum < 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= rsp_word;
    end

endmodule

`default_nettype wire

[design/sprite_blit_framebuffer_top.sv]
// Top level of the monochrome sprite blitter with its frame store.
`default_nettype none

// Monochrome frame store of SCREEN_WIDTH x SCREEN_HEIGHT pixels in 8-row pages
// (byte page*SCREEN_WIDTH + x, bit n is row page*8+n) with a sprite blitter.
// Each request word is a draw byte, an erase byte or a frame store read; each
// gives exactly one response word. A draw or erase word lands on up to two
// store bytes with one read-modify-write pass for each through the store's
// single write port. A read word makes a single pass, and a word's final pass
// only starts once the response queue is certain to have room for it. A
// response goes from the request register through the modify stage registers
// into a two-word queue, so requests keep flowing while a response waits.
// After reset the store is cleared one byte per cycle, all SCREEN_WIDTH *
// ceil(SCREEN_HEIGHT/8) bytes (1024 by default), and no request is taken
// until that sweep ends.
module sprite_blit_framebuffer_top #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  sbf_pkg::sbf_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output sbf_pkg::sbf_rsp_t rsp
);

    import sbf_pkg::*;

    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_DEPTH = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    logic              mem_busy;
    logic              final_room;
    logic              op_valid;
    sbf_op_t           op;
    logic [ADDR_W-1:0] op_addr;
    logic [7:0]        rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    // Request side: counters and access generation
    sbf_issue #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_issue (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .mem_busy   (mem_busy),
        .final_room (final_room),
        .op_valid   (op_valid),
        .op         (op),
        .op_addr    (op_addr)
    );

    // Frame store
    sbf_frame_mem #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (op_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .busy    (mem_busy)
    );

    // Modify, write back and respond
    sbf_rmw #(
        .ADDR_W (ADDR_W)
    ) u_rmw (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (op_valid),
        .op         (op),
        .op_addr    (op_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .final_room (final_room),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

[tb/sv/sprite_blit_framebuffer_top_test.sv]
// Self-checking testbench for the sprite blitter and its monochrome frame store.
`default_nettype none

module sprite_blit_framebuffer_top_test;
    import sbf_pkg::*;

    localparam int SCREEN_W   = 128;
    localparam int SCREEN_H   = 64;
    localparam int PAGES      = (SCREEN_H + 7) / 8;
    localparam int STORE_SIZE = SCREEN_W * PAGES;

    // Mode code that the block ignores
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_WORDS = 690;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 6000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    sbf_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    sbf_rsp_t rsp;

    sprite_blit_framebuffer_top #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Shadow of the frame store and the sprite position counters
    logic [7:0] shadow_store [STORE_SIZE];
    logic [7:0] sprite_col;
    logic [4:0] sprite_band;

    sbf_rsp_t predicted_rsp [$];

    int mismatches   = 0;
    int words_sent   = 0;
    int read_words   = 0;
    int blit_words   = 0;
    int sprites_done = 0;
    int rsp_checked  = 0;

    bit gaps_enabled      = 1'b1;
    int burst_left        = 0;
    bit hold_off_request  = 1'b0;

    function automatic bit pixel_visible(int x, int y);
        return x >= 0 && x < SCREEN_W && y >= 0 && y < SCREEN_H;
    endfunction

    function automatic void paint_pixel(int x, int y, bit set);
        int idx;
        if (!pixel_visible(x, y))
            return;
        idx = (y / 8) * SCREEN_W + x;
        if (set)
            shadow_store[idx][y % 8] = 1'b1;
        else
            shadow_store[idx][y % 8] = 1'b0;
    endfunction

    // Applies one request word to the shadow state and gives the response it causes
    function automatic sbf_rsp_t blit_predict(sbf_req_t w);
        sbf_rsp_t r;
        int       px;
        int       py;
        int       row;
        bit       draw;
        r    = '0;
        px   = int'($signed(w.pos_x));
        py   = int'($signed(w.pos_y));
        draw = (w.mode == MODE_DRAW);
        case (w.mode)
            MODE_READ:
            begin
                if (px >= 0 && px < SCREEN_W && py >= 0 && py < PAGES)
                    r.read_data = shadow_store[py * SCREEN_W + px];
            end
            MODE_DRAW, MODE_ERASE:
            begin
                // erase only acts when the sprite origin is on screen
                if ((draw || pixel_visible(px, py)) && sprite_col < w.sprite_width)
                begin
                    for (int n = 0; n < 8; n++)
                    begin
                        row = int'(sprite_band) * 8 + n;
                        if (w.data_byte[n] && row < int'(w.sprite_height))
                            paint_pixel(px + int'(sprite_col), py + row, draw);
                    end
                end
                if (w.last_byte)
                begin
                    sprite_col    = '0;
                    sprite_band   = '0;
                    r.sprite_done = 1'b1;
                end
                else
                begin
                    sprite_col = sprite_col + 8'd1;
                    if (sprite_col >= w.sprite_width || sprite_col == 8'd0)
                    begin
                        sprite_col  = '0;
                        sprite_band = sprite_band + 5'd1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Response checking and prediction on accepted request words
    always @(posedge clk)
    begin
        sbf_rsp_t exp_rsp;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (predicted_rsp.size() == 0)
            begin
                $error("response word with none expected: read_data %0h sprite_done %0b",
                       rsp.read_data, rsp.sprite_done);
                mismatches++;
            end
            else
            begin
                exp_rsp = predicted_rsp.pop_front();
                rsp_checked++;
                if (rsp.read_data !== exp_rsp.read_data)
                begin
                    $error("read_data: expected %0h, actual %0h",
                           exp_rsp.read_data, rsp.read_data);
                    mismatches++;
                end
                if (rsp.sprite_done !== exp_rsp.sprite_done)
                begin
                    $error("sprite_done: expected %0b, actual %0b",
                           exp_rsp.sprite_done, rsp.sprite_done);
                    mismatches++;
                end
                if (exp_rsp.sprite_done)
                    sprites_done++;
            end
        end
        if (rst_n && req_valid && req_ready)
        begin
            predicted_rsp.push_back(blit_predict(req));
            if (req.mode == MODE_READ)
                read_words++;
            else if (req.mode != MODE_UNUSED)
                blit_words++;
        end
    end

    // Receiver: changing stall patterns, plus a long hold-off on request
    int rx_cycle  = 0;
    int hold_left = 0;
    always @(posedge clk)
    begin
        rx_cycle++;
        if (hold_off_request)
        begin
            hold_off_request = 1'b0;
            hold_left        = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            case ((rx_cycle / 97) % 4)
                0:       rsp_ready <= 1'b1;
                1:       rsp_ready <= 1'($urandom_range(0, 1));
                2:       rsp_ready <= ($urandom_range(0, 5) == 0);
                default: rsp_ready <= ((rx_cycle % 5) < 2);
            endcase
        end
    end

    // Watchdog on cycles without any accepted word
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no word accepted for %0d cycles", IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic sbf_req_t make_word(logic [1:0] op, int x, int y, int wd, int ht,
                                           int d, bit last);
        sbf_req_t w;
        w.mode          = op;
        w.pos_x         = x[15:0];
        w.pos_y         = y[15:0];
        w.sprite_width  = wd[7:0];
        w.sprite_height = ht[7:0];
        w.data_byte     = d[7:0];
        w.last_byte     = last;
        return w;
    endfunction

    // Offers one word and holds it until taken; idles between bursts
    task automatic send_word(input sbf_req_t w);
        int gap;
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (w.mode != MODE_UNUSED)
            words_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
            if (gaps_enabled && gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic read_byte(input int x, input int page);
        send_word(make_word(MODE_READ, x, page, $urandom, $urandom, $urandom,
                            1'($urandom)));
    endtask

    // Complete sprite: width times bands bytes, last flag on the final one
    task automatic send_sprite(input logic [1:0] op, input int x, input int y,
                               input int wd, input int ht);
        int bands;
        int total;
        bands = (ht + 7) / 8;
        if (bands == 0)
            bands = 1;
        total = wd * bands;
        for (int k = 0; k < total; k++)
            send_word(make_word(op, x, y, wd, ht, $urandom, k == total - 1));
    endtask

    // Extremes of the fields, every mode and the corner cases
    task automatic test_directed_corners();
        read_byte(0, 0);
        read_byte(SCREEN_W - 1, PAGES - 1);
        read_byte(-1, 0);
        read_byte(SCREEN_W, 0);
        read_byte(0, PAGES);
        read_byte(-32768, 32767);
        read_byte(32767, -1);
        send_word(make_word(MODE_UNUSED, -1, -1, 255, 255, 255, 1'b1));
        // unaligned sprite clipped at the bottom right corner
        send_word(make_word(MODE_DRAW, 126, 60, 2, 10, 8'hff, 1'b0));
        send_word(make_word(MODE_DRAW, 126, 60, 2, 10, 8'hff, 1'b0));
        send_word(make_word(MODE_DRAW, 126, 60, 2, 10, 8'hff, 1'b0));
        send_word(make_word(MODE_DRAW, 126, 60, 2, 10, 8'hff, 1'b1));
        read_byte(126, 7);
        read_byte(127, 7);
        // clipped at negative position
        send_word(make_word(MODE_DRAW, -1, -3, 3, 8, 8'hff, 1'b0));
        send_word(make_word(MODE_DRAW, -1, -3, 3, 8, 8'hff, 1'b0));
        send_word(make_word(MODE_DRAW, -1, -3, 3, 8, 8'hff, 1'b1));
        // erase with origin off screen leaves the store alone
        send_word(make_word(MODE_ERASE, -1, -3, 1, 8, 8'hff, 1'b1));
        read_byte(0, 0);
        // erase on screen, one pixel
        send_word(make_word(MODE_ERASE, 0, 2, 1, 255, 8'h01, 1'b1));
        // zero width paints nothing but moves the band
        send_word(make_word(MODE_DRAW, 0, 8, 0, 8, 8'hff, 1'b0));
        send_word(make_word(MODE_DRAW, 0, 8, 0, 8, 8'hff, 1'b1));
        // far off screen and zero height
        send_word(make_word(MODE_DRAW, 32767, -32768, 255, 255, 8'hff, 1'b1));
        send_word(make_word(MODE_DRAW, 5, 5, 1, 0, 8'hff, 1'b1));
        read_byte(0, 0);
        read_byte(0, 1);
    endtask

    // Mostly complete sprites with random content, reads near them, and noise
    task automatic test_random_sprites();
        int         sel;
        int         x;
        int         y;
        int         wd;
        int         ht;
        int         cut;
        logic [1:0] op;
        sbf_req_t   w;
        while (words_sent < RANDOM_WORDS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
            begin
                op = ($urandom_range(0, 99) < 65) ? MODE_DRAW : MODE_ERASE;
                if ($urandom_range(0, 9) == 0)
                begin
                    x = $signed(16'($urandom));
                    y = $signed(16'($urandom));
                end
                else
                begin
                    x = $urandom_range(0, 160) - 20;
                    y = $urandom_range(0, 100) - 20;
                end
                sel = $urandom_range(0, 99);
                if (sel < 80)
                begin
                    wd = $urandom_range(1, 16);
                    ht = $urandom_range(1, 24);
                end
                else if (sel < 95)
                begin
                    wd = $urandom_range(17, 64);
                    ht = $urandom_range(1, 8);
                end
                else if (sel < 98)
                begin
                    wd = $urandom_range(1, 3);
                    ht = $urandom_range(100, 255);
                end
                else
                begin
                    wd = $urandom_range(200, 255);
                    ht = $urandom_range(1, 8);
                end
                send_sprite(op, x, y, wd, ht);
                repeat ($urandom_range(1, 4))
                    read_byte(x + $urandom_range(0, wd),
                              (y >>> 3) + $urandom_range(0, (ht + 7) / 8));
            end
            else if (sel < 80)
            begin
                if ($urandom_range(0, 9) == 0)
                    read_byte($signed(16'($urandom)), $signed(16'($urandom)));
                else
                    read_byte($urandom_range(0, SCREEN_W - 1), $urandom_range(0, PAGES - 1));
            end
            else if (sel < 92)
            begin
                // any field value at all, the unused mode among them
                w = sbf_req_t'({$urandom, $urandom});
                send_word(w);
            end
            else
            begin
                // broken sprite: cut short, width changed part way
                x   = $urandom_range(0, 140) - 6;
                y   = $urandom_range(0, 70) - 6;
                wd  = $urandom_range(2, 12);
                cut = $urandom_range(1, wd * 2);
                for (int k = 0; k < cut; k++)
                begin
                    if (k == cut / 2)
                        wd = $urandom_range(0, 12);
                    send_word(make_word(MODE_DRAW, x, y, wd, 16, $urandom,
                                        (k == cut - 1) && $urandom_range(0, 1)));
                end
            end
        end
    endtask

    // Receiver holds off for a long stretch while words keep coming
    task automatic test_back_pressure();
        gaps_enabled     = 1'b0;
        hold_off_request = 1'b1;
        send_sprite(MODE_DRAW, 40, 20, 8, 16);
        for (int k = 0; k < 24; k++)
            read_byte(40 + (k % 8), 2 + (k / 8) % 3);
        gaps_enabled = 1'b1;
    endtask

    // Reads back every byte of the store
    task automatic test_store_sweep();
        for (int page = 0; page < PAGES; page++)
            for (int x = 0; x < SCREEN_W; x++)
                read_byte(x, page);
    endtask

    initial
    begin
        for (int i = 0; i < STORE_SIZE; i++)
            shadow_store[i] = '0;
        sprite_col  = '0;
        sprite_band = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_random_sprites();
        test_back_pressure();
        test_store_sweep();
        req_valid <= 1'b0;

        while (predicted_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (predicted_rsp.size() != 0 || rsp_valid)
        begin
            $error("responses out of step at the end: %0d still expected, valid %0b",
                   predicted_rsp.size(), rsp_valid);
            mismatches++;
        end

        $display("run covered %0d words: %0d draw/erase bytes, %0d store reads, %0d sprites",
                 words_sent, blit_words, read_words, sprites_done);
        $display("%0d responses checked, %0d mismatches", rsp_checked, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
